@@ hw/rtl/rss_pkg.sv @@
// shared constants for the rss toeplitz hash block
package rss_pkg;

  localparam int KEY_WORDS  = 5;
  localparam int WORD_W     = 64;
  localparam int KEY_BITS   = KEY_WORDS * WORD_W;
  localparam int KEY_BYTES  = 40;
  localparam int CFG_IDX_W  = $clog2(KEY_WORDS);

  localparam int HASH_W     = 32;
  localparam int PORT_W     = 16;
  localparam int V4_ADDR_W  = 32;
  localparam int V6_ADDR_W  = 2 * WORD_W;

  // longest tuple: two ipv6 addresses and two ports
  localparam int TUPLE_BITS = 2 * V6_ADDR_W + 2 * PORT_W;
  localparam int V4_BITS    = 2 * V4_ADDR_W + 2 * PORT_W;

  localparam int NUM_LANES  = 8;
  localparam int LANE_BITS  = TUPLE_BITS / NUM_LANES;
  localparam int LANE_KEY_W = LANE_BITS + HASH_W - 1;

  // key bits past the key length read as zero
  localparam int KEY_USED_BITS = (KEY_BYTES * 8 < KEY_BITS) ? KEY_BYTES * 8 : KEY_BITS;
  localparam logic [KEY_BITS-1:0] KEY_MASK = {KEY_BITS{1'b1}} << (KEY_BITS - KEY_USED_BITS);

  // hash variants
  localparam logic OP_STANDARD  = 1'b0;
  localparam logic OP_SYMMETRIC = 1'b1;

endpackage

@@ hw/rtl/rss_tuple.sv @@
// assembles the hashed byte string of one flow tuple, first bit in the msb
module rss_tuple (
  input  logic                            op,
  input  logic                            is_ipv6,
  input  logic [rss_pkg::WORD_W-1:0]      src_addr_hi,
  input  logic [rss_pkg::WORD_W-1:0]      src_addr_lo,
  input  logic [rss_pkg::WORD_W-1:0]      dst_addr_hi,
  input  logic [rss_pkg::WORD_W-1:0]      dst_addr_lo,
  input  logic [rss_pkg::PORT_W-1:0]      sport,
  input  logic [rss_pkg::PORT_W-1:0]      dport,
  output logic [rss_pkg::TUPLE_BITS-1:0]  tuple
);

  logic [rss_pkg::V6_ADDR_W-1:0] sa;
  logic [rss_pkg::V6_ADDR_W-1:0] da;
  logic [rss_pkg::V6_ADDR_W-1:0] a0;
  logic [rss_pkg::V6_ADDR_W-1:0] a1;
  logic [rss_pkg::PORT_W-1:0]    p0;
  logic [rss_pkg::PORT_W-1:0]    p1;

  assign sa = {src_addr_hi, src_addr_lo};
  assign da = {dst_addr_hi, dst_addr_lo};

  always_comb begin
    if (op == rss_pkg::OP_SYMMETRIC) begin
      a0 = sa | da;
      a1 = sa ^ da;
      p0 = sport | dport;
      p1 = sport ^ dport;
    end else begin
      a0 = sa;
      a1 = da;
      p0 = sport;
      p1 = dport;
    end
  end

  // ipv4 uses the low 32 bits of each address; trailing bits are zero and add nothing
  always_comb begin
    if (is_ipv6) begin
      tuple = {a0, a1, p0, p1};
    end else begin
      tuple = {a0[rss_pkg::V4_ADDR_W-1:0], a1[rss_pkg::V4_ADDR_W-1:0], p0, p1,
               {(rss_pkg::TUPLE_BITS - rss_pkg::V4_BITS){1'b0}}};
    end
  end

endmodule

@@ hw/rtl/rss_lane.sv @@
// one hash lane: xor of the key windows for its slice of tuple bits, registered
module rss_lane (
  input  logic                            clk,
  input  logic                            load,
  input  logic [rss_pkg::LANE_BITS-1:0]   data_bits,
  input  logic [rss_pkg::LANE_KEY_W-1:0]  key_win,
  output logic [rss_pkg::HASH_W-1:0]      part
);

  logic [rss_pkg::HASH_W-1:0] acc;
  logic [rss_pkg::HASH_W-1:0] part_r;

  // bit j of the slice (counted from the msb) selects the window starting at key bit j
  always_comb begin
    acc = '0;
    for (int j = 0; j < rss_pkg::LANE_BITS; j++) begin
      if (data_bits[rss_pkg::LANE_BITS-1-j]) begin
        acc = acc ^ key_win[rss_pkg::LANE_KEY_W-1-j -: rss_pkg::HASH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part_r <= acc;
    end
  end

  assign part = part_r;

endmodule

@@ hw/rtl/rss_toeplitz_hash_top.sv @@
// rss toeplitz hash: a 40-byte key in five 64-bit words hashes one ipv4 or ipv6
// flow tuple per clock while the output is taken. The tuple is assembled and
// registered, eight lanes each fold the key windows of 36 tuple bits into a
// registered partial hash, and a merge stage xors the partials into the output
// register. Each stage holds its item only while the next one is full and
// stalled, so one item per cycle flows through whenever the output is taken.
// Key words are written through cfg_we, cfg_idx and cfg_wdata; the user must
// write them only while no item is in flight, as the block does not enforce it.
// Indexes past the fifth word are ignored.
module rss_toeplitz_hash_top (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rss_pkg::WORD_W-1:0]        cfg_wdata,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic                              in_is_ipv6,
  input  logic [rss_pkg::WORD_W-1:0]        in_src_addr_hi,
  input  logic [rss_pkg::WORD_W-1:0]        in_src_addr_lo,
  input  logic [rss_pkg::WORD_W-1:0]        in_dst_addr_hi,
  input  logic [rss_pkg::WORD_W-1:0]        in_dst_addr_lo,
  input  logic [rss_pkg::PORT_W-1:0]        in_src_port,
  input  logic [rss_pkg::PORT_W-1:0]        in_dst_port,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rss_pkg::HASH_W-1:0]        out_hash
);

  logic [rss_pkg::WORD_W-1:0]     key_r [rss_pkg::KEY_WORDS];
  logic [rss_pkg::KEY_BITS-1:0]   key_vec;
  logic [rss_pkg::KEY_BITS-1:0]   key_eff;

  logic [rss_pkg::TUPLE_BITS-1:0] tuple;
  logic [rss_pkg::TUPLE_BITS-1:0] tuple_r;
  logic                           s1_vld_r;
  logic                           s2_vld_r;
  logic                           out_vld_r;
  logic [rss_pkg::HASH_W-1:0]     out_hash_r;
  logic [rss_pkg::HASH_W-1:0]     hash_nxt;

  logic                           out_ready;
  logic                           s2_ready;
  logic                           s1_ready;
  logic                           lane_load;

  logic [rss_pkg::HASH_W-1:0]     part [rss_pkg::NUM_LANES];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < rss_pkg::KEY_WORDS; w++) begin
        key_r[w] <= '0;
      end
    end else if (cfg_we && (32'(cfg_idx) < rss_pkg::KEY_WORDS)) begin
      key_r[cfg_idx] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int w = 0; w < rss_pkg::KEY_WORDS; w++) begin
      key_vec[rss_pkg::KEY_BITS-1-w*rss_pkg::WORD_W -: rss_pkg::WORD_W] = key_r[w];
    end
  end

  assign key_eff = key_vec & rss_pkg::KEY_MASK;

  // stage handshake
  assign out_ready = !out_vld_r || !out_stall;
  assign s2_ready  = !s2_vld_r || out_ready;
  assign s1_ready  = !s1_vld_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign lane_load = s2_ready && s1_vld_r;

  rss_tuple u_tuple (
    .op          (in_op),
    .is_ipv6     (in_is_ipv6),
    .src_addr_hi (in_src_addr_hi),
    .src_addr_lo (in_src_addr_lo),
    .dst_addr_hi (in_dst_addr_hi),
    .dst_addr_lo (in_dst_addr_lo),
    .sport       (in_src_port),
    .dport       (in_dst_port),
    .tuple       (tuple)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      tuple_r <= tuple;
    end
  end

  // lane k covers tuple bits k*LANE_BITS onward and the key windows starting there
  for (genvar k = 0; k < rss_pkg::NUM_LANES; k++) begin : g_lane
    rss_lane u_lane (
      .clk       (clk),
      .load      (lane_load),
      .data_bits (tuple_r[rss_pkg::TUPLE_BITS-1-k*rss_pkg::LANE_BITS -: rss_pkg::LANE_BITS]),
      .key_win   (key_eff[rss_pkg::KEY_BITS-1-k*rss_pkg::LANE_BITS -: rss_pkg::LANE_KEY_W]),
      .part      (part[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // merge lanes
  always_comb begin
    hash_nxt = '0;
    for (int k = 0; k < rss_pkg::NUM_LANES; k++) begin
      hash_nxt = hash_nxt ^ part[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ready) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_vld_r) begin
      out_hash_r <= hash_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_hash  = out_hash_r;

endmodule
